>>> hw/rtl/multicast_group_slot_table_top_macros.svh
// Assertion macros for the multicast group slot table.
// Depends on nothing; included by the RTL files that carry assertions.
`ifndef MULTICAST_GROUP_SLOT_TABLE_TOP_MACROS_SVH
`define MULTICAST_GROUP_SLOT_TABLE_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define MGST_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mgst assertion failed");

// next-cycle implication, disabled in reset
`define MGST_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mgst assertion failed");

`endif

>>> hw/rtl/mgst_pkg.sv
// Types and constants shared by the multicast group slot table.
// Depends on nothing.
package mgst_pkg;

   localparam int GROUP_W = 24;
   localparam int MEMBER_W = 31;
   localparam int MAP_W = 32;
   localparam int SLOT_W = 6;
   localparam int ROUTER_W = 6;

   typedef enum logic [1:0] {
      ACT_ADD    = 2'd0,
      ACT_REMOVE = 2'd1,
      ACT_FULL   = 2'd2
   } action_type;

   typedef struct packed {
      logic [GROUP_W-1:0]  group_address;
      logic [MEMBER_W-1:0] member_ports;
   } req_type;

   typedef struct packed {
      action_type          action;
      logic [SLOT_W-1:0]   slot;
      logic [MAP_W-1:0]    port_map_written;
      logic [GROUP_W-1:0]  group_echo;
   } rsp_type;

   // search flags handed from cell to cell
   typedef struct packed {
      logic               active;
      logic [GROUP_W-1:0] group;
      logic               hit;
      logic               free;
   } probe_type;

   // slot update broadcast to all cells
   typedef struct packed {
      logic               en;
      logic               valid;
      logic [GROUP_W-1:0] group;
   } wr_type;

endpackage

>>> hw/rtl/mgst_cell.sv
// One table slot: valid flag and group, plus one stage of the search chain.
// Depends on mgst_pkg.
module mgst_cell #(
   parameter int IDX_W = 6,
   parameter int CELL_IDX = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  mgst_pkg::probe_type   probe_in,
   input  logic [IDX_W-1:0]      hit_idx_in,
   input  logic [IDX_W-1:0]      free_idx_in,
   output mgst_pkg::probe_type   probe_out,
   output logic [IDX_W-1:0]      hit_idx_out,
   output logic [IDX_W-1:0]      free_idx_out,
   input  mgst_pkg::wr_type      wr,
   input  logic [IDX_W-1:0]      wr_idx
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

   logic                          valid_ff, valid_in;
   logic [mgst_pkg::GROUP_W-1:0]  group_ff, group_in;
   mgst_pkg::probe_type           probe_ff, probe_in_nx;
   logic [IDX_W-1:0]              hit_idx_ff, hit_idx_in_nx;
   logic [IDX_W-1:0]              free_idx_ff, free_idx_in_nx;
   logic                          hit_here;
   logic                          sel_me;

   assign hit_here = valid_ff && (group_ff == probe_in.group);
   assign sel_me   = wr.en && (wr_idx == MY_IDX);

   always_comb begin
      probe_in_nx        = probe_in;
      probe_in_nx.hit    = probe_in.hit || hit_here;
      probe_in_nx.free   = probe_in.free || !valid_ff;
      hit_idx_in_nx      = probe_in.hit ? hit_idx_in : MY_IDX;
      free_idx_in_nx     = probe_in.free ? free_idx_in : MY_IDX;
      valid_in           = sel_me ? wr.valid : valid_ff;
      group_in           = sel_me ? wr.group : group_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff        <= 1'b0;
         probe_ff.active <= 1'b0;
      end else begin
         valid_ff        <= valid_in;
         probe_ff.active <= probe_in_nx.active;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      group_ff       <= group_in;
      probe_ff.group <= probe_in_nx.group;
      probe_ff.hit   <= probe_in_nx.hit;
      probe_ff.free  <= probe_in_nx.free;
      hit_idx_ff     <= hit_idx_in_nx;
      free_idx_ff    <= free_idx_in_nx;
   end

   assign probe_out    = probe_ff;
   assign hit_idx_out  = hit_idx_ff;
   assign free_idx_out = free_idx_ff;

endmodule

>>> hw/rtl/multicast_group_slot_table_top.sv
// Multicast group slot table: top level with control and the chain of slot cells.
// Depends on mgst_pkg, mgst_cell and multicast_group_slot_table_top_macros.svh.
// Flow: a request is taken only in the idle state; its probe walks the cell chain one
//   slot per cycle, then the chosen slot is committed and the response registered once
//   the response register is free. No new request is taken until that commit.
// Reset: synchronous, active high; clears every slot's valid flag and
//   sets the router port to none (-1). No clearing pass.
`include "multicast_group_slot_table_top_macros.svh"

module multicast_group_slot_table_top #(
   parameter int TABLE_SLOTS = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  mgst_pkg::req_type                    req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output mgst_pkg::rsp_type                    rsp_payload,
   input  logic                                 csr_write_enable,
   input  logic signed [mgst_pkg::ROUTER_W-1:0] csr_write_data
);

   localparam int IDX_W = $clog2(TABLE_SLOTS);

   // one-hot control sequencer
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,  // waiting for a request
      ST_SCAN = 3'b010,  // probe walking the chain
      ST_DONE = 3'b100   // search result held, commit when response slot frees
   } state_type;

   state_type                            state_ff, state_in;
   logic signed [mgst_pkg::ROUTER_W-1:0] router_ff, router_in;
   mgst_pkg::req_type                    req_ff, req_in;
   logic                                 hit_ff, free_ff;
   logic [IDX_W-1:0]                     hit_idx_ff, free_idx_ff;
   logic                                 rsp_valid_ff, rsp_valid_in;
   mgst_pkg::rsp_type                    rsp_ff, rsp_in;

   // chain taps: entry 0 is the injected probe, entry k+1 is cell k's output
   mgst_pkg::probe_type                  chain_probe [TABLE_SLOTS+1];
   logic [IDX_W-1:0]                     chain_hit_idx [TABLE_SLOTS+1];
   logic [IDX_W-1:0]                     chain_free_idx [TABLE_SLOTS+1];
   mgst_pkg::probe_type                  chain_exit;

   mgst_pkg::wr_type                     wr;
   logic [IDX_W-1:0]                     wr_idx;
   logic                                 req_accept;
   logic                                 commit;
   logic [IDX_W-1:0]                     chosen_idx;
   logic [IDX_W+mgst_pkg::SLOT_W-1:0]    chosen_ext;
   logic [mgst_pkg::MAP_W-1:0]           add_map;
   logic [mgst_pkg::MAP_W-1:0]           router_bit;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // probe enters cell 0 on the accepting edge, with the slot state already current
   always_comb begin
      chain_probe[0].active = req_accept;
      chain_probe[0].group  = req_payload.group_address;
      chain_probe[0].hit    = 1'b0;
      chain_probe[0].free   = 1'b0;
      chain_hit_idx[0]      = '0;
      chain_free_idx[0]     = '0;
   end

   genvar k;
   generate
      for (k = 0; k < TABLE_SLOTS; k++) begin : g_cell
         mgst_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (k)
         ) u_cell (
            .clock        (clock),
            .reset        (reset),
            .probe_in     (chain_probe[k]),
            .hit_idx_in   (chain_hit_idx[k]),
            .free_idx_in  (chain_free_idx[k]),
            .probe_out    (chain_probe[k+1]),
            .hit_idx_out  (chain_hit_idx[k+1]),
            .free_idx_out (chain_free_idx[k+1]),
            .wr           (wr),
            .wr_idx       (wr_idx)
         );
      end
   endgenerate

   assign chain_exit = chain_probe[TABLE_SLOTS];

   // a match wins over the first free slot; neither means full
   assign chosen_idx = hit_ff ? hit_idx_ff : free_idx_ff;
   assign chosen_ext = {{mgst_pkg::SLOT_W{1'b0}}, chosen_idx};

   // negative router port means none
   assign router_bit = router_ff[mgst_pkg::ROUTER_W-1] ? '0 :
                       (mgst_pkg::MAP_W'(1) << router_ff[4:0]);
   assign add_map    = {req_ff.member_ports, 1'b0} | router_bit;

   assign commit = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in     = state_ff;
      router_in    = csr_write_enable ? csr_write_data : router_ff;
      req_in       = req_accept ? req_payload : req_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      wr.en        = 1'b0;
      wr.valid     = 1'b0;
      wr.group     = req_ff.group_address;
      wr_idx       = chosen_idx;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (chain_exit.active) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (commit) begin
               state_in                = ST_IDLE;
               rsp_valid_in            = 1'b1;
               rsp_in.group_echo       = req_ff.group_address;
               if (!hit_ff && !free_ff) begin
                  // table full: nothing written
                  rsp_in.action           = mgst_pkg::ACT_FULL;
                  rsp_in.slot             = '0;
                  rsp_in.port_map_written = '0;
               end else if (req_ff.member_ports != '0) begin
                  wr.en                   = 1'b1;
                  wr.valid                = 1'b1;
                  rsp_in.action           = mgst_pkg::ACT_ADD;
                  rsp_in.slot             = chosen_ext[mgst_pkg::SLOT_W-1:0];
                  rsp_in.port_map_written = add_map;
               end else begin
                  // remove, also of a slot that was already free
                  wr.en                   = 1'b1;
                  wr.valid                = 1'b0;
                  rsp_in.action           = mgst_pkg::ACT_REMOVE;
                  rsp_in.slot             = chosen_ext[mgst_pkg::SLOT_W-1:0];
                  rsp_in.port_map_written = '0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         router_ff    <= -6'sd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         router_ff    <= router_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
      if (chain_exit.active) begin
         hit_ff      <= chain_exit.hit;
         free_ff     <= chain_exit.free;
         hit_idx_ff  <= chain_hit_idx[TABLE_SLOTS];
         free_idx_ff <= chain_free_idx[TABLE_SLOTS];
      end
   end

   `MGST_ASSERT_NEXT(a_accept_starts_scan, clock, reset, req_accept, state_ff == ST_SCAN)
   `MGST_ASSERT_IMPL(a_exit_only_in_scan, clock, reset, chain_exit.active, state_ff == ST_SCAN)
   `MGST_ASSERT_IMPL(a_write_only_on_commit, clock, reset, wr.en, commit && (hit_ff || free_ff))
   `MGST_ASSERT_IMPL(a_full_is_empty, clock, reset, rsp_valid_ff && (rsp_ff.action == mgst_pkg::ACT_FULL), (rsp_ff.slot == '0) && (rsp_ff.port_map_written == '0))

endmodule

>>> tb/tb_multicast_group_slot_table_top.sv
// Self-checking testbench for the multicast group slot table top level.
// Depends on mgst_pkg and multicast_group_slot_table_top; holds its own table predictor.
`timescale 1ns / 100ps

// Table predictor plus ordered store of the responses it expects.
class slot_table_scoreboard;
   localparam int SLOTS = 64;

   logic                                 slot_used [SLOTS];
   logic [mgst_pkg::GROUP_W-1:0]         slot_group [SLOTS];
   logic [mgst_pkg::MAP_W-1:0]           slot_map [SLOTS];
   logic signed [mgst_pkg::ROUTER_W-1:0] router_port;
   mgst_pkg::rsp_type                    expected_rsp [$];
   int                                   errors;

   function new();
      for (int i = 0; i < SLOTS; i++) begin
         slot_used[i] = 1'b0;
         slot_group[i] = '0;
         slot_map[i] = '0;
      end
      router_port = -1;
      errors = 0;
   endfunction

   function void set_router(logic signed [mgst_pkg::ROUTER_W-1:0] port);
      router_port = port;
   endfunction

   function int pending();
      return expected_rsp.size();
   endfunction

   // Accepted request: search, update the table, queue the response.
   function void note_request(mgst_pkg::req_type req);
      int                hit_at;
      int                free_at;
      int                chosen;
      mgst_pkg::rsp_type rsp;
      hit_at = -1;
      free_at = -1;
      for (int i = 0; i < SLOTS; i++) begin
         if (hit_at < 0 && slot_used[i] && slot_group[i] == req.group_address)
            hit_at = i;
         if (free_at < 0 && !slot_used[i])
            free_at = i;
      end
      chosen = (hit_at >= 0) ? hit_at : free_at;
      rsp.group_echo = req.group_address;
      rsp.port_map_written = '0;
      if (chosen < 0) begin
         rsp.action = mgst_pkg::ACT_FULL;
         rsp.slot = '0;
      end else if (req.member_ports != '0) begin
         rsp.port_map_written = {req.member_ports, 1'b0};
         if (!router_port[mgst_pkg::ROUTER_W-1])
            rsp.port_map_written[router_port[4:0]] = 1'b1;
         slot_used[chosen] = 1'b1;
         slot_group[chosen] = req.group_address;
         slot_map[chosen] = rsp.port_map_written;
         rsp.action = mgst_pkg::ACT_ADD;
         rsp.slot = chosen[mgst_pkg::SLOT_W-1:0];
      end else begin
         slot_used[chosen] = 1'b0;
         slot_group[chosen] = '0;
         slot_map[chosen] = '0;
         rsp.action = mgst_pkg::ACT_REMOVE;
         rsp.slot = chosen[mgst_pkg::SLOT_W-1:0];
      end
      expected_rsp.push_back(rsp);
   endfunction

   function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s expected %h actual %h", $time, field, want, got);
      end
   endfunction

   function void check_response(mgst_pkg::rsp_type got);
      mgst_pkg::rsp_type want;
      if (expected_rsp.size() == 0) begin
         errors++;
         $display("%0t: response with nothing expected, actual %h", $time, got);
         return;
      end
      want = expected_rsp.pop_front();
      compare_field("action", 32'(want.action), 32'(got.action));
      compare_field("slot", 32'(want.slot), 32'(got.slot));
      compare_field("port_map_written", want.port_map_written, got.port_map_written);
      compare_field("group_echo", 32'(want.group_echo), 32'(got.group_echo));
   endfunction
endclass

module tb_multicast_group_slot_table_top;

   localparam int SLOTS       = 64;
   localparam int CYCLE_LIMIT = 600000;
   localparam int RANDOM_ITEMS = 650;
   // long enough for a search to walk the whole chain, with a margin
   localparam int SETTLE      = SLOTS + 8;

   logic                                 clock;
   logic                                 reset;
   logic                                 req_valid;
   logic                                 req_ready;
   mgst_pkg::req_type                    req_payload;
   logic                                 rsp_valid;
   logic                                 rsp_ready;
   mgst_pkg::rsp_type                    rsp_payload;
   logic                                 csr_write_enable;
   logic signed [mgst_pkg::ROUTER_W-1:0] csr_write_data;

   slot_table_scoreboard table_sb = new();
   int unsigned cycle_count = 0;
   // set during one stretch to run both sides without any idling
   bit          no_gaps = 1'b0;
   int          random_sent = 0;

   multicast_group_slot_table_top #(
      .TABLE_SLOTS(SLOTS)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // Response side: random stalls, checking and the run-time guard.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         rsp_ready <= no_gaps || ($urandom_range(0, 99) >= 9);
         if (!reset && rsp_valid && rsp_ready)
            table_sb.check_response(rsp_payload);
      end
   end

   // Present one request and hold it until the block takes it. Valid stays
   // high on return so that back-to-back requests never toggle it.
   task automatic push_request(input logic [mgst_pkg::GROUP_W-1:0] grp,
                               input logic [mgst_pkg::MEMBER_W-1:0] members);
      mgst_pkg::req_type req;
      req.group_address = grp;
      req.member_ports = members;
      if (!no_gaps && $urandom_range(0, 99) < 9) begin
         repeat ($urandom_range(1, 80)) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_payload <= req;
      do
         @(posedge clock);
      while (!req_ready);
      table_sb.note_request(req);
   endtask

   // Drop valid and hold off until every expected response is back.
   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (table_sb.pending() != 0)
         @(posedge clock);
   endtask

   // Router port write, only with the block idle.
   task automatic write_router(input logic signed [mgst_pkg::ROUTER_W-1:0] port);
      drain_responses();
      repeat (SETTLE) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= port;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      table_sb.set_router(port);
   endtask

   function automatic logic [mgst_pkg::MEMBER_W-1:0] random_members();
      case ($urandom_range(0, 3))
         0: return mgst_pkg::MEMBER_W'($urandom);
         1: return mgst_pkg::MEMBER_W'(1) << $urandom_range(0, mgst_pkg::MEMBER_W - 1);
         2: return '1;
         default: return mgst_pkg::MEMBER_W'($urandom_range(1, 255));
      endcase
   endfunction

   // Requests over a small pool of groups: hits, updates, removes, some noise.
   task automatic churn_phase(input int pool_size, input int count);
      logic [mgst_pkg::GROUP_W-1:0] pool [$];
      logic [mgst_pkg::GROUP_W-1:0] grp;
      for (int i = 0; i < pool_size; i++)
         pool.push_back(mgst_pkg::GROUP_W'($urandom));
      if ($urandom_range(0, 1)) pool.push_back('0);
      if ($urandom_range(0, 1)) pool.push_back('1);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < 5)
            grp = mgst_pkg::GROUP_W'($urandom);
         else
            grp = pool[$urandom_range(0, pool.size() - 1)];
         if ($urandom_range(0, 99) < 25)
            push_request(grp, '0);
         else
            push_request(grp, random_members());
         random_sent++;
      end
   endtask

   // Add more groups than there are slots, poke the full table, then
   // remove every pool group again (absent ones pick the first free slot).
   task automatic fill_phase();
      logic [mgst_pkg::GROUP_W-1:0] pool [$];
      int                           extra;
      extra = $urandom_range(2, 8);
      for (int i = 0; i < SLOTS + extra; i++)
         pool.push_back(mgst_pkg::GROUP_W'($urandom));
      foreach (pool[i]) push_request(pool[i], random_members());
      push_request(mgst_pkg::GROUP_W'($urandom), '0);
      push_request(mgst_pkg::GROUP_W'($urandom), random_members());
      push_request(pool[$urandom_range(0, SLOTS - 1)], random_members());
      pool.shuffle();
      foreach (pool[i]) push_request(pool[i], '0);
      random_sent += 2 * pool.size() + 3;
   endtask

   initial begin
      int                                   phase;
      logic signed [mgst_pkg::ROUTER_W-1:0] port;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      rsp_ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: router port at its reset value (none)
      push_request(24'h000000, 31'h00000001);
      push_request(24'hFFFFFF, 31'h7FFFFFFF);
      push_request(24'h000000, 31'h00000004);      // update in place
      push_request(24'h000000, 31'h00000000);      // remove a present group
      push_request(24'h123456, 31'h00000000);      // remove of an absent group
      push_request(24'h123456, 31'h2AAAAAAA);
      push_request(24'hFFFFFF, 31'h00000000);
      write_router(6'sd31);
      push_request(24'h000001, 31'h55555555);
      push_request(24'hFFFFFF, 31'h00000001);
      write_router(6'sd0);
      push_request(24'h800000, 31'h40000000);
      push_request(24'h000000, 31'h7FFFFFFF);
      write_router(-6'sd32);                       // negative but not -1: still none
      push_request(24'h7FFFFF, 31'h00000001);
      push_request(24'h123456, 31'h00000000);

      // random phases, each under its own router port setting
      phase = 0;
      while (random_sent < RANDOM_ITEMS) begin
         case (phase % 5)
            0: port = -1;
            1: port = 31;
            2: port = 0;
            3: port = -32;
            default: port = mgst_pkg::ROUTER_W'($urandom_range(0, 63));
         endcase
         write_router(port);
         no_gaps = (phase == 2);
         if (phase % 4 == 3)
            fill_phase();
         else
            churn_phase($urandom_range(2, 48), $urandom_range(30, 80));
         drain_responses();
         phase++;
      end
      no_gaps = 1'b0;

      drain_responses();
      repeat (SETTLE) @(posedge clock);
      if (table_sb.errors == 0 && table_sb.pending() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
